[rtl/core/wsd_pkg.sv]
package wsd_pkg;

  // parse phases, one-hot
  typedef enum logic [8:0] {
    PH_HDR0  = 9'b000000001,
    PH_HDR1  = 9'b000000010,
    PH_EXT0  = 9'b000000100,
    PH_EXT1  = 9'b000001000,
    PH_MASK0 = 9'b000010000,
    PH_MASK1 = 9'b000100000,
    PH_MASK2 = 9'b001000000,
    PH_MASK3 = 9'b010000000,
    PH_DATA  = 9'b100000000
  } phase_t;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_BIN     = 3'd1;
  localparam logic [2:0] EV_TEXT    = 3'd2;
  localparam logic [2:0] EV_PONG    = 3'd3;
  localparam logic [2:0] EV_CLOSE   = 3'd4;
  localparam logic [2:0] EV_IGNORED = 3'd5;
  localparam logic [2:0] EV_BADLEN  = 3'd6;
  localparam logic [2:0] EV_TOOLONG = 3'd7;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [15:0] MAX_LEN_RST = 16'd2048;

  typedef struct packed {
    logic       is_event;
    logic [7:0] data_byte;
    logic       frame_is_text;
    logic [2:0] event_code;
    logic       last;
  } res_t;

  function automatic res_t mk_event(input logic [2:0] code);
    res_t r;
    r = '0;
    r.is_event   = 1'b1;
    r.event_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic logic [2:0] end_code(input logic [3:0] opcode);
    logic [2:0] c;
    unique case (opcode)
      OP_CLOSE: c = EV_CLOSE;
      OP_PING:  c = EV_PONG;
      OP_TEXT:  c = EV_TEXT;
      OP_BIN:   c = EV_BIN;
      default:  c = EV_IGNORED;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/websocket_frame_deframer.sv]
// channel | dir | tdata            | tuser                                 | tlast
// in_     | in  | rx_byte[7:0]     | -                                     | -
// out_    | out | data_byte[7:0]   | is_event, frame_is_text, event_code   | last
// cfg_    | in  | max_payload_len  | -                                     | -
//
// One received byte is taken per clock; its results are formed in the same cycle and
// written into a four-entry result queue that drains one result per clock while out_tready is high.
// The last payload byte of a text/binary frame yields two results; in_tready drops
// while fewer than two queue slots are free.
// rst_n is synchronous, active low; max_payload_len resets to 2048. cfg_ready is always 1.
// After a bad length code or an oversized frame all bytes are dropped until reset.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_byte
  output logic [4:0]  out_tuser,  // [0] is_event, [1] frame_is_text, [4:2] event_code
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // max_payload_len
);

  localparam int QDEPTH = 4;

  logic [15:0]           max_len_r;
  wsd_pkg::phase_t       phase_r, phase_nxt;
  logic [3:0]            opcode_r, opcode_nxt;
  logic                  mask_r, mask_nxt;
  logic [15:0]           len_r, len_nxt;
  logic [15:0]           cnt_r, cnt_nxt;
  logic [7:0]            key_r [4];
  logic [7:0]            key_nxt [4];
  logic                  halted_r, halted_nxt;

  wsd_pkg::res_t         q_r [QDEPTH];
  logic [1:0]            wr_ptr_r, rd_ptr_r;
  logic [2:0]            fill_r;

  logic                  in_fire, pop, hdr_done, fin, shown;
  logic [1:0]            n_res;
  wsd_pkg::res_t         res0, res1;
  logic [15:0]           cnt_inc;
  logic [7:0]            plain;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (fill_r <= 3'(QDEPTH - 2));
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (fill_r != 3'd0);
  assign pop        = out_tvalid && out_tready;

  assign out_tdata  = q_r[rd_ptr_r].data_byte;
  assign out_tuser  = {q_r[rd_ptr_r].event_code, q_r[rd_ptr_r].frame_is_text,
                       q_r[rd_ptr_r].is_event};
  assign out_tlast  = q_r[rd_ptr_r].last;

  assign cnt_inc = cnt_r + 16'd1;
  assign fin     = (cnt_inc >= len_r);
  assign shown   = (opcode_r == wsd_pkg::OP_TEXT) || (opcode_r == wsd_pkg::OP_BIN);
  assign plain   = mask_r ? (in_tdata ^ key_r[cnt_r[1:0]]) : in_tdata;

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    halted_nxt = halted_r;
    hdr_done   = 1'b0;
    n_res      = 2'd0;
    res0       = '0;
    res1       = '0;
    if (in_fire && !halted_r) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR0: begin
          opcode_nxt = in_tdata[3:0];
          phase_nxt  = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          mask_nxt = in_tdata[7];
          if (in_tdata[6:0] == wsd_pkg::LEN_EXT64) begin
            halted_nxt = 1'b1;
            res0       = wsd_pkg::mk_event(wsd_pkg::EV_BADLEN);
            n_res      = 2'd1;
          end else if (in_tdata[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_nxt = wsd_pkg::PH_EXT0;
          end else begin
            len_nxt = {9'd0, in_tdata[6:0]};
            if (in_tdata[7]) begin
              phase_nxt = wsd_pkg::PH_MASK0;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsd_pkg::PH_EXT0: begin
          len_nxt   = {in_tdata, 8'd0};
          phase_nxt = wsd_pkg::PH_EXT1;
        end
        wsd_pkg::PH_EXT1: begin
          len_nxt = {len_r[15:8], in_tdata};
          if (mask_r) begin
            phase_nxt = wsd_pkg::PH_MASK0;
          end else begin
            hdr_done = 1'b1;
          end
        end
        wsd_pkg::PH_MASK0: begin
          key_nxt[0] = in_tdata;
          phase_nxt  = wsd_pkg::PH_MASK1;
        end
        wsd_pkg::PH_MASK1: begin
          key_nxt[1] = in_tdata;
          phase_nxt  = wsd_pkg::PH_MASK2;
        end
        wsd_pkg::PH_MASK2: begin
          key_nxt[2] = in_tdata;
          phase_nxt  = wsd_pkg::PH_MASK3;
        end
        wsd_pkg::PH_MASK3: begin
          key_nxt[3] = in_tdata;
          hdr_done   = 1'b1;
        end
        wsd_pkg::PH_DATA: begin
          cnt_nxt = cnt_inc;
          if (shown) begin
            res0.data_byte     = plain;
            res0.frame_is_text = (opcode_r == wsd_pkg::OP_TEXT);
            res0.last          = !fin;
            if (fin) begin
              res1  = wsd_pkg::mk_event(wsd_pkg::end_code(opcode_r));
              n_res = 2'd2;
            end else begin
              n_res = 2'd1;
            end
          end else if (fin) begin
            res0  = wsd_pkg::mk_event(wsd_pkg::end_code(opcode_r));
            n_res = 2'd1;
          end
          if (fin) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      endcase
      if (hdr_done) begin
        priority if (len_nxt == 16'd0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
          res0      = wsd_pkg::mk_event(wsd_pkg::EV_IGNORED);
          n_res     = 2'd1;
        end else if (len_nxt > max_len_r) begin
          halted_nxt = 1'b1;
          res0       = wsd_pkg::mk_event(wsd_pkg::EV_TOOLONG);
          n_res      = 2'd1;
        end else begin
          cnt_nxt   = 16'd0;
          phase_nxt = wsd_pkg::PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wsd_pkg::MAX_LEN_RST;
      phase_r   <= wsd_pkg::PH_HDR0;
      opcode_r  <= 4'd0;
      mask_r    <= 1'b0;
      len_r     <= 16'd0;
      cnt_r     <= 16'd0;
      key_r     <= '{default: 8'd0};
      halted_r  <= 1'b0;
      wr_ptr_r  <= 2'd0;
      rd_ptr_r  <= 2'd0;
      fill_r    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      halted_r <= halted_nxt;
      wr_ptr_r <= wr_ptr_r + n_res;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      fill_r   <= fill_r + {1'b0, n_res} - {2'd0, pop};
    end
  end

  // result queue storage; entries are only read behind fill_r
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'(QDEPTH)) else $error("result queue overflow");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt flag cleared without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (n_res == 2'd0)) else $error("result produced while halted");

  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast) else $error("event without tlast");

  a_data_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tuser[4:2] == wsd_pkg::EV_NONE))
    else $error("data transfer carries event code");
`endif

endmodule
